@@ sv/lopa_pkg.sv @@
`default_nettype none
package lopa_pkg;

  localparam int unsigned MAX_OBJECTS      = 256;
  localparam int unsigned HEADER_BYTES     = 64;
  localparam int unsigned MIN_ALIGN_BYTES  = 8;
  localparam int unsigned MIN_OBJECT_BYTES = 16;
  localparam int unsigned BATCH_MAX        = 16;
  localparam int unsigned MAX_ALIGN_LOG2   = 12;

  localparam int unsigned STACK_AW = $clog2(MAX_OBJECTS);
  localparam int unsigned COUNT_W  = $clog2(MAX_OBJECTS + 1);
  localparam int unsigned ALIGN_W  = MAX_ALIGN_LOG2 + 1;
  localparam int unsigned ALEN_W   = 17;
  localparam int unsigned BATCH_W  = 5;

  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_TAKE   = 2'd1,
    REQ_RETURN = 2'd2,
    REQ_BATCH  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_POOL_LENGTH = 2'd1,
    REG_OBJ_LENGTH  = 2'd2,
    REG_ALIGN_LOG2  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_LOOP,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [31:0] pool_base;
    logic [31:0] pool_length;
    logic [15:0] object_length;
    logic [3:0]  align_log2;
  } cfg_t;

  typedef struct packed {
    logic    pop;
    logic    push;
    logic    load_rem;
    logic    res_load;
    status_e res_status;
    logic    res_mem;
    logic    res_batch;
    logic    init_prep;
    logic    init_step;
    logic    init_done;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic take_ok;
    logic batch_ok;
    logic ret_zero;
    logic ret_full;
    logic init_bad;
    logic init_fits;
    logic more;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/lopa_ctrl.sv @@
`default_nettype none
module lopa_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  input  wire [1:0]         req_type_i,
  input  lopa_pkg::sts_t    sts_i,
  output lopa_pkg::cmd_t    cmd_o,
  output logic              busy
);
  import lopa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d        = S_EMIT;
          cmd_o.res_load = 1'b1;
          case (req_e'(req_type_i))
            REQ_INIT: begin
              if (sts_i.init_bad) begin
                cmd_o.res_status = ST_NOSPACE;
              end else begin
                cmd_o.res_load  = 1'b0;
                cmd_o.init_prep = 1'b1;
                state_d         = S_PREP;
              end
            end
            REQ_TAKE: begin
              if (sts_i.take_ok) begin
                cmd_o.pop     = 1'b1;
                cmd_o.res_mem = 1'b1;
              end else begin
                cmd_o.res_status = ST_NOMEM;
              end
            end
            REQ_RETURN: begin
              if (sts_i.ret_zero) begin
                cmd_o.res_status = ST_OK;
              end else if (sts_i.ret_full) begin
                cmd_o.res_status = ST_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            REQ_BATCH: begin
              cmd_o.load_rem = 1'b1;
              if (sts_i.batch_ok) begin
                cmd_o.pop       = 1'b1;
                cmd_o.res_mem   = 1'b1;
                cmd_o.res_batch = 1'b1;
              end else begin
                cmd_o.res_status = ST_NOMEM;
              end
            end
            default: begin
              cmd_o.res_status = ST_NOMEM;
            end
          endcase
        end
      end
      S_PREP: begin
        state_d = S_LOOP;
      end
      S_LOOP: begin
        if (sts_i.init_fits) begin
          cmd_o.init_step = 1'b1;
        end else begin
          cmd_o.init_done = 1'b1;
          cmd_o.res_load  = 1'b1;
          state_d         = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        // A batch keeps popping while objects are wanted and left.
        if (sts_i.more) begin
          cmd_o.pop = 1'b1;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

@@ sv/lopa_dp.sv @@
`default_nettype none
module lopa_dp (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  lopa_pkg::cfg_t     cfg_i,
  input  lopa_pkg::cmd_t     cmd_i,
  output lopa_pkg::sts_t     sts_o,
  input  wire [31:0]         request_size_i,
  input  wire [31:0]         request_align_i,
  input  wire [31:0]         address_i,
  input  wire [4:0]          batch_count_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [31:0]        object_address_o,
  output logic [8:0]         free_objects_o,
  output logic [31:0]        avail_bytes_o,
  output logic               last_o
);
  import lopa_pkg::*;

  logic [31:0] stack_mem [MAX_OBJECTS];
  logic [31:0] rdata_q;

  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] total_q, total_d;
  logic [COUNT_W-1:0] n_q, n_d;
  logic [ALEN_W-1:0]  alen_q, alen_d;
  logic [ALIGN_W-1:0] ealign_q, ealign_d;
  logic [32:0]        end_q, end_d;
  logic [33:0]        ptr_q, ptr_d;
  logic [BATCH_W-1:0] rem_q, rem_d;
  logic               done_q;
  status_e            res_status_q;
  logic               res_mem_q;
  logic               res_batch_q;

  // Init preparation, taken straight from the configuration registers.
  logic [3:0]         lg;
  logic [ALIGN_W-1:0] align_raw, align_eff;
  logic [ALEN_W-1:0]  olen, align_m1, alen_new;
  logic [32:0]        end_raw;
  logic [33:0]        ptr_raw;
  logic [33:0]        ptr_next;
  logic [BATCH_W-1:0] want;
  logic [COUNT_W-1:0] count_m1;
  logic [25:0]        bytes;

  always_comb begin
    lg        = (cfg_i.align_log2 > 4'(MAX_ALIGN_LOG2)) ? 4'(MAX_ALIGN_LOG2)
                                                         : cfg_i.align_log2;
    align_raw = ALIGN_W'(1) << lg;
    align_eff = (align_raw < ALIGN_W'(MIN_ALIGN_BYTES)) ? ALIGN_W'(MIN_ALIGN_BYTES)
                                                        : align_raw;
    olen      = (cfg_i.object_length < 16'(MIN_OBJECT_BYTES))
                ? ALEN_W'(MIN_OBJECT_BYTES) : ALEN_W'(cfg_i.object_length);
    align_m1  = ALEN_W'(align_eff) - ALEN_W'(1);
    alen_new  = (olen + align_m1) & ~align_m1;
    end_raw   = {1'b0, cfg_i.pool_base} + {1'b0, cfg_i.pool_length};
    if (end_raw > 33'h1_0000_0000) begin
      end_raw = 33'h1_0000_0000;
    end
    ptr_raw   = ({2'b00, cfg_i.pool_base} + 34'(HEADER_BYTES) + 34'(align_m1))
                & ~34'(align_m1);
    ptr_next  = ptr_q + 34'(alen_q);
    want      = (batch_count_i > BATCH_W'(BATCH_MAX)) ? BATCH_W'(BATCH_MAX)
                                                      : batch_count_i;
    count_m1  = count_q - COUNT_W'(1);
  end

  assign sts_o.take_ok   = (request_size_i <= 32'(alen_q))
                        && (request_align_i <= 32'(ealign_q))
                        && (count_q != '0);
  assign sts_o.batch_ok  = (want != '0) && (count_q != '0);
  assign sts_o.ret_zero  = (address_i == 32'd0);
  assign sts_o.ret_full  = (count_q >= total_q)
                        || (count_q >= COUNT_W'(MAX_OBJECTS));
  assign sts_o.init_bad  = (cfg_i.pool_base == 32'd0)
                        || (cfg_i.pool_length < 32'(HEADER_BYTES));
  assign sts_o.init_fits = (ptr_next <= {1'b0, end_q})
                        && (n_q < COUNT_W'(MAX_OBJECTS));
  assign sts_o.more      = res_batch_q && (rem_q != '0) && (count_q != '0);

  always_comb begin
    count_d  = count_q;
    total_d  = total_q;
    n_d      = n_q;
    alen_d   = alen_q;
    ealign_d = ealign_q;
    end_d    = end_q;
    ptr_d    = ptr_q;
    rem_d    = cmd_i.load_rem ? want : rem_q;
    if (cmd_i.pop) begin
      count_d = count_m1;
      rem_d   = rem_d - BATCH_W'(1);
    end
    if (cmd_i.push) begin
      count_d = count_q + COUNT_W'(1);
    end
    if (cmd_i.init_prep) begin
      alen_d   = alen_new;
      ealign_d = align_eff;
      end_d    = end_raw;
      ptr_d    = ptr_raw;
      n_d      = '0;
    end
    if (cmd_i.init_step) begin
      n_d   = n_q + COUNT_W'(1);
      ptr_d = ptr_next;
    end
    if (cmd_i.init_done) begin
      total_d = n_q;
      count_d = n_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      total_q  <= '0;
      alen_q   <= '0;
      ealign_q <= '0;
      done_q   <= 1'b0;
    end else begin
      count_q  <= count_d;
      total_q  <= total_d;
      alen_q   <= alen_d;
      ealign_q <= ealign_d;
      done_q   <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    end_q <= end_d;
    ptr_q <= ptr_d;
    rem_q <= rem_d;
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_mem_q    <= cmd_i.res_mem;
      res_batch_q  <= cmd_i.res_batch;
    end
  end

  // Free stack: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_mem[count_q[STACK_AW-1:0]] <= address_i;
    end else if (cmd_i.init_step) begin
      stack_mem[n_q[STACK_AW-1:0]] <= ptr_q[31:0];
    end
    if (cmd_i.pop) begin
      rdata_q <= stack_mem[count_m1[STACK_AW-1:0]];
    end
  end

  assign bytes = 26'(count_q) * 26'(alen_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_o         <= res_status_q;
      object_address_o <= res_mem_q ? rdata_q : 32'd0;
      free_objects_o   <= count_q;
      avail_bytes_o    <= 32'(bytes);
      last_o           <= !sts_o.more;
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

@@ sv/lifo_object_pool_allocator.sv @@
// Take and return: done_o is registered from the emit state that the request leads to,
// and a new request is accepted only once the block is idle again, not while it is busy.
// Batch take of k objects: one result per cycle, with the block busy until the last is emitted.
// Init of N objects: a prepare step, then one free-stack write per cycle, then the result.
// Reset clears the counts and restores the register defaults; stack contents stay
// undefined until init writes them. The receiver cannot stall results.
`default_nettype none
module lifo_object_pool_allocator (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  req_type_i,
  input  wire  [31:0] request_size_i,
  input  wire  [31:0] request_align_i,
  input  wire  [31:0] address_i,
  input  wire  [4:0]  batch_count_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] object_address_o,
  output logic [8:0]  free_objects_o,
  output logic [31:0] avail_bytes_o,
  output logic        last_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lopa_pkg::*;

  cfg_t     cfg_q;
  cmd_t     cmd;
  sts_t     sts;
  cfg_reg_e reg_sel;

  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_base     <= 32'd0;
      cfg_q.pool_length   <= 32'd0;
      cfg_q.object_length <= 16'd16;
      cfg_q.align_log2    <= 4'd3;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_POOL_BASE:   cfg_q.pool_base     <= pwdata;
        REG_POOL_LENGTH: cfg_q.pool_length   <= pwdata;
        REG_OBJ_LENGTH:  cfg_q.object_length <= pwdata[15:0];
        REG_ALIGN_LOG2:  cfg_q.align_log2    <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POOL_BASE:   prdata = cfg_q.pool_base;
      REG_POOL_LENGTH: prdata = cfg_q.pool_length;
      REG_OBJ_LENGTH:  prdata = {16'd0, cfg_q.object_length};
      REG_ALIGN_LOG2:  prdata = {28'd0, cfg_q.align_log2};
      default:         prdata = 32'd0;
    endcase
  end

  lopa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  lopa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .request_size_i   (request_size_i),
    .request_align_i  (request_align_i),
    .address_i        (address_i),
    .batch_count_i    (batch_count_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .object_address_o (object_address_o),
    .free_objects_o   (free_objects_o),
    .avail_bytes_o    (avail_bytes_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

@@ sv/lopa_chk.sv @@
`default_nettype none
module lopa_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        start,
  input wire        busy,
  input wire [1:0]  status_o,
  input wire [31:0] object_address_o,
  input wire [8:0]  free_objects_o,
  input wire        done_o,
  input wire        last_o
);
  import lopa_pkg::*;

  // An accepted request always keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted request");

  // Batch results follow one another without gaps until the last one.
  a_batch_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !last_o) |=> done_o)
    else $error("gap inside a batch");

  // A failed request ends at once and hands out no object.
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (last_o && (object_address_o == 32'd0)))
    else $error("failed result is not a single empty result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (free_objects_o <= 9'(MAX_OBJECTS)))
    else $error("free object count beyond the stack depth");

endmodule

bind lifo_object_pool_allocator lopa_chk u_lopa_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .status_o         (status_o),
  .object_address_o (object_address_o),
  .free_objects_o   (free_objects_o),
  .done_o           (done_o),
  .last_o           (last_o)
);
`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lopa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_REQUESTS = 480;

  typedef struct {
    status_e     status;
    logic [31:0] addr;
    logic [8:0]  nfree;
    logic [31:0] nbytes;
    logic        last;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = REQ_INIT;
  logic [31:0] request_size = '0;
  logic [31:0] request_align = '0;
  logic [31:0] address = '0;
  logic [4:0]  batch_count = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] object_address_o;
  logic [8:0]  free_objects_o;
  logic [31:0] avail_bytes_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Pool model: configuration, free stack and derived object geometry.
  logic [31:0]     cfg_base = '0;
  logic [31:0]     cfg_plen = '0;
  logic [15:0]     cfg_olen = 16'd16;
  logic [3:0]      cfg_alog = 4'd3;
  logic [31:0]     free_stack_m [MAX_OBJECTS];
  int unsigned     free_m = 0;
  int unsigned     total_m = 0;
  longint unsigned alen_m = 0;
  longint unsigned align_m = 0;

  reply_t      pool_replies[$];
  logic [31:0] lent_addrs[$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned cycle_count = 0;
  bit          no_gaps = 1'b0;

  lifo_object_pool_allocator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type),
    .request_size_i  (request_size),
    .request_align_i (request_align),
    .address_i       (address),
    .batch_count_i   (batch_count),
    .done_o          (done_o),
    .status_o        (status_o),
    .object_address_o(object_address_o),
    .free_objects_o  (free_objects_o),
    .avail_bytes_o   (avail_bytes_o),
    .last_o          (last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void note_reply(status_e st, logic [31:0] a, logic lst);
    reply_t r;
    longint unsigned b;
    b = free_m;
    b = b * alen_m;
    if (b > 64'hFFFF_FFFF) b = 64'hFFFF_FFFF;
    r.status = st;
    r.addr   = a;
    r.nfree  = free_m[8:0];
    r.nbytes = b[31:0];
    r.last   = lst;
    pool_replies.push_back(r);
  endfunction

  function automatic status_e carve_pool();
    longint unsigned lg, al, ol, al_len, stop, ptr;
    int unsigned n;
    if (cfg_base == 0 || cfg_plen < HEADER_BYTES) return ST_NOSPACE;
    lg = (cfg_alog > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : cfg_alog;
    al = 64'd1 << lg;
    if (al < MIN_ALIGN_BYTES) al = MIN_ALIGN_BYTES;
    ol = (cfg_olen < MIN_OBJECT_BYTES) ? MIN_OBJECT_BYTES : cfg_olen;
    al_len = (ol + al - 1) / al * al;
    stop = cfg_base;
    stop = stop + cfg_plen;
    // The region never reaches past the 32-bit address space.
    if (stop > 64'h1_0000_0000) stop = 64'h1_0000_0000;
    ptr = cfg_base;
    ptr = (ptr + HEADER_BYTES + al - 1) / al * al;
    n = 0;
    while (ptr <= stop && stop - ptr >= al_len && n < MAX_OBJECTS) begin
      free_stack_m[n] = ptr[31:0];
      n++;
      ptr += al_len;
    end
    total_m = n;
    free_m  = n;
    alen_m  = al_len;
    align_m = al;
    lent_addrs.delete();
    return ST_OK;
  endfunction

  function automatic void apply_request(req_e rt, logic [31:0] sz, logic [31:0] al,
                                        logic [31:0] ad, logic [4:0] cnt);
    status_e st;
    int unsigned want, k;
    case (rt)
      REQ_INIT: begin
        st = carve_pool();
        note_reply(st, '0, 1'b1);
      end
      REQ_TAKE: begin
        if (sz > alen_m || al > align_m || free_m == 0) begin
          note_reply(ST_NOMEM, '0, 1'b1);
        end else begin
          free_m--;
          lent_addrs.push_back(free_stack_m[free_m]);
          note_reply(ST_OK, free_stack_m[free_m], 1'b1);
        end
      end
      REQ_RETURN: begin
        if (ad == 0) begin
          note_reply(ST_OK, '0, 1'b1);
        end else if (free_m >= total_m || free_m >= MAX_OBJECTS) begin
          note_reply(ST_FULL, '0, 1'b1);
        end else begin
          free_stack_m[free_m] = ad;
          free_m++;
          note_reply(ST_OK, '0, 1'b1);
        end
      end
      default: begin
        want = (cnt > BATCH_MAX) ? BATCH_MAX : cnt;
        k = 0;
        while (k < want && free_m > 0) begin
          free_m--;
          k++;
          lent_addrs.push_back(free_stack_m[free_m]);
          note_reply(ST_OK, free_stack_m[free_m], (k == want) || (free_m == 0));
        end
        if (k == 0) note_reply(ST_NOMEM, '0, 1'b1);
      end
    endcase
  endfunction

  // Results cannot be held off, so each strobe is checked at the edge that ends it.
  always @(posedge clk_i) begin
    reply_t w;
    if (rst_ni && done_o === 1'b1) begin
      if (pool_replies.size() == 0) begin
        $error("unexpected result: status %0d address %0h", status_o, object_address_o);
        mismatches++;
      end else begin
        w = pool_replies.pop_front();
        if (status_o !== w.status) begin
          $error("status: expected %0d, actual %0d", w.status, status_o);
          mismatches++;
        end
        if (object_address_o !== w.addr) begin
          $error("object_address: expected %0h, actual %0h", w.addr, object_address_o);
          mismatches++;
        end
        if (free_objects_o !== w.nfree) begin
          $error("free_objects: expected %0d, actual %0d", w.nfree, free_objects_o);
          mismatches++;
        end
        if (avail_bytes_o !== w.nbytes) begin
          $error("avail_bytes: expected %0d, actual %0d", w.nbytes, avail_bytes_o);
          mismatches++;
        end
        if (last_o !== w.last) begin
          $error("last: expected %0d, actual %0d", w.last, last_o);
          mismatches++;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic send_request(req_e rt, logic [31:0] sz, logic [31:0] al,
                              logic [31:0] ad, logic [4:0] cnt);
    int unsigned gap;
    req_type      <= rt;
    request_size  <= sz;
    request_align <= al;
    address       <= ad;
    batch_count   <= cnt;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    apply_request(rt, sz, al, ad, cnt);
    requests_sent++;
    gap = pick_gap();
    // With no gap, start stays high and the next request follows at once.
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pool_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_POOL_BASE:   cfg_base = val;
      REG_POOL_LENGTH: cfg_plen = val;
      REG_OBJ_LENGTH:  cfg_olen = val[15:0];
      default:         cfg_alog = val[3:0];
    endcase
  endtask

  task automatic set_pool(logic [31:0] base, logic [31:0] len, logic [15:0] olen,
                          logic [3:0] alog);
    wait_idle();
    write_reg(REG_POOL_BASE, base);
    write_reg(REG_POOL_LENGTH, len);
    write_reg(REG_OBJ_LENGTH, {16'h0, olen});
    write_reg(REG_ALIGN_LOG2, {28'h0, alog});
  endtask

  task automatic return_lent();
    int unsigned i;
    logic [31:0] a;
    if (lent_addrs.size() == 0) begin
      a = $urandom();
    end else begin
      i = $urandom_range(0, lent_addrs.size() - 1);
      a = lent_addrs[i];
      lent_addrs.delete(i);
    end
    send_request(REQ_RETURN, '0, '0, a, '0);
  endtask

  // With the register defaults the base is zero, so init is refused.
  task automatic test_before_init();
    send_request(REQ_TAKE, '0, '0, '0, '0);
    send_request(REQ_RETURN, '0, '0, 32'h1234_5678, '0);
    send_request(REQ_RETURN, '0, '0, '0, '0);
    send_request(REQ_BATCH, '0, '0, '0, 5'd5);
    send_request(REQ_INIT, '0, '0, '0, '0);
  endtask

  task automatic test_init_limits();
    set_pool(32'h0000_1000, 32'd63, 16'd16, 4'd3);
    send_request(REQ_INIT, '0, '0, '0, '0);
    // Only the header fits, so the pool is ready but empty.
    set_pool(32'h0000_1000, 32'd64, 16'd0, 4'd0);
    send_request(REQ_INIT, '0, '0, '0, '0);
    send_request(REQ_TAKE, '0, '0, '0, '0);
    send_request(REQ_RETURN, '0, '0, 32'h0000_1040, '0);
    set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd16, 4'd3);
    send_request(REQ_INIT, '0, '0, '0, '0);
    // Largest objects at the top of the address space, alignment above the cap.
    set_pool(32'hFFF0_0000, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);
    send_request(REQ_INIT, '0, '0, '0, '0);
    send_request(REQ_BATCH, '0, '0, '0, 5'd31);
    send_request(REQ_TAKE, '0, '0, '0, '0);
    return_lent();
    return_lent();
    send_request(REQ_TAKE, 32'hFFFF_FFFF, '0, '0, '0);
    send_request(REQ_TAKE, 32'h0001_0000, 32'd4096, '0, '0);
  endtask

  task automatic test_take_return_edges();
    set_pool(32'h0000_0100, 32'hFFFF_FFFF, 16'd16, 4'd3);
    send_request(REQ_INIT, '0, '0, '0, '0);
    send_request(REQ_RETURN, '0, '0, 32'hFFFF_FFFF, '0);
    send_request(REQ_TAKE, 32'd16, 32'd8, '0, '0);
    send_request(REQ_TAKE, 32'd17, '0, '0, '0);
    send_request(REQ_TAKE, '0, 32'hFFFF_FFFF, '0, '0);
    send_request(REQ_BATCH, '0, '0, '0, 5'd0);
    send_request(REQ_BATCH, '0, '0, '0, 5'd16);
    send_request(REQ_RETURN, '0, '0, 32'hFFFF_FFFF, '0);
    send_request(REQ_RETURN, '0, '0, '0, '0);
  endtask

  task automatic pick_pool();
    logic [31:0] base, len;
    logic [15:0] olen;
    logic [3:0]  alog;
    int unsigned r, span;
    r = $urandom_range(0, 19);
    base = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
    if (base > 32'hFFFF_0000 && r > 1) base = base - 32'h0100_0000;
    alog = $urandom_range(0, 15);
    r = $urandom_range(0, 9);
    olen = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
           (r < 6) ? 16'($urandom_range(0, 64)) : 16'($urandom_range(0, 1024));
    span = $urandom_range(0, 40) * 2 * (olen + (1 << ((alog > 12) ? 12 : alog)) + 16);
    r = $urandom_range(0, 19);
    if (r == 0) len = $urandom_range(0, 63);
    else if (r < 3) len = $urandom();
    else len = 64 + $urandom_range(0, span);
    set_pool(base, len, olen, alog);
    send_request(REQ_INIT, '0, '0, '0, '0);
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at, n, r;
    logic [31:0] sz, al;
    stop_at = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < stop_at) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      pick_pool();
      n = $urandom_range(25, 60);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          r = $urandom_range(0, 99);
          sz = (r < 40) ? 32'h0 : (r < 85) ? 32'($urandom_range(0, alen_m + 1)) : $urandom();
          r = $urandom_range(0, 99);
          al = (r < 50) ? 32'h0 : (r < 85) ? (32'h1 << $urandom_range(0, 13)) : $urandom();
          send_request(REQ_TAKE, sz, al, '0, '0);
        end else if (r < 70) begin
          r = $urandom_range(0, 9);
          if (r < 7) return_lent();
          else if (r == 7) send_request(REQ_RETURN, '0, '0, '0, '0);
          else send_request(REQ_RETURN, '0, '0, $urandom(), '0);
        end else if (r < 92) begin
          r = $urandom_range(0, 9);
          send_request(REQ_BATCH, '0, '0, '0,
                       (r < 7) ? 5'($urandom_range(1, 16)) :
                       (r < 9) ? 5'($urandom_range(17, 31)) : 5'd0);
        end else if (r < 95) begin
          send_request(REQ_INIT, '0, '0, '0, '0);
        end else begin
          // Hold off until every outstanding request has been answered.
          wait_idle();
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_init();
    test_init_limits();
    test_take_return_edges();
    test_random_traffic();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
